@@ hdl/hae_pkg.sv @@
// Shared types and constants for the header address extractor.
// No dependencies; compiled first.
package hae_pkg;

   typedef enum logic [2:0] {
      ST_PRE    = 3'd0,
      ST_ADDR   = 3'd1,
      ST_QUOTE  = 3'd2,
      ST_CMT    = 3'd3,
      ST_ANGLE  = 3'd4,
      ST_AQUOTE = 3'd5,
      ST_DONE   = 3'd6
   } parse_state_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_APPEND  = 3'd1,
      ACT_DISCARD = 3'd2,
      ACT_DONE    = 3'd3,
      ACT_END     = 3'd4,
      ACT_BAD     = 3'd5
   } action_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LANGLE = 8'h3C;
   localparam logic [7:0] CH_RANGLE = 8'h3E;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

@@ hdl/hae_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on nothing; payload widths are fixed.
interface hae_req_if;
   logic       valid;
   logic       ready;
   logic       new_header;
   logic [7:0] in_byte;

   modport source (output valid, output new_header, output in_byte, input ready);
   modport sink   (input valid, input new_header, input in_byte, output ready);
endinterface

interface hae_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] out_byte;

   modport source (output valid, output action, output out_byte, input ready);
   modport sink   (input valid, input action, input out_byte, output ready);
endinterface

@@ hdl/hae_parser.sv @@
// Header parse state machine: state register plus per-byte action decode.
// Depends on hae_pkg.
module hae_parser
   import hae_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            new_header,
   input  logic [7:0]      in_byte,
   output action_type      action_in,
   output logic [7:0]      out_byte_in
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PRE;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cur       = new_header ? ST_PRE : state_ff;
      state_in  = cur;
      action_in = ACT_NONE;
      if (in_byte == CH_NUL) begin
         action_in = ACT_END;
         state_in  = ST_DONE;
      end else begin
         unique case (cur)
            ST_PRE: begin
               if (in_byte == CH_LF) begin
                  action_in = ACT_END;
                  state_in  = ST_DONE;
               end else if (in_byte == CH_COLON) begin
                  action_in = ACT_DISCARD;
                  state_in  = ST_ADDR;
               end
            end
            ST_ADDR: begin
               priority if (in_byte == CH_LF) begin
                  action_in = ACT_DONE;
                  state_in  = ST_DONE;
               end else if (in_byte == CH_COMMA) begin
                  action_in = ACT_DONE;
               end else if (in_byte == CH_DQUOTE) begin
                  action_in = ACT_APPEND;
                  state_in  = ST_QUOTE;
               end else if (in_byte == CH_LPAREN) begin
                  state_in  = ST_CMT;
               end else if (in_byte == CH_LANGLE) begin
                  action_in = ACT_DISCARD;
                  state_in  = ST_ANGLE;
               end else if (!is_space(in_byte)) begin
                  action_in = ACT_APPEND;
               end
            end
            ST_QUOTE: begin
               if (in_byte == CH_LF) begin
                  action_in = ACT_BAD;
                  state_in  = ST_DONE;
               end else begin
                  action_in = ACT_APPEND;
                  if (in_byte == CH_DQUOTE) state_in = ST_ADDR;
               end
            end
            ST_CMT: begin
               if (in_byte == CH_LF) begin
                  action_in = ACT_BAD;
                  state_in  = ST_DONE;
               end else if (in_byte == CH_RPAREN) begin
                  state_in  = ST_ADDR;
               end
            end
            ST_ANGLE: begin
               // newline inside brackets is kept as an ordinary byte
               if (in_byte == CH_RANGLE) begin
                  action_in = ACT_DONE;
                  state_in  = ST_ADDR;
               end else if (in_byte == CH_LANGLE) begin
                  action_in = ACT_DISCARD;
               end else begin
                  action_in = ACT_APPEND;
                  if (in_byte == CH_DQUOTE) state_in = ST_AQUOTE;
               end
            end
            ST_AQUOTE: begin
               if (in_byte == CH_LF) begin
                  action_in = ACT_BAD;
                  state_in  = ST_DONE;
               end else begin
                  action_in = ACT_APPEND;
                  if (in_byte == CH_DQUOTE) state_in = ST_ANGLE;
               end
            end
            default: begin
               action_in = ACT_END;
               state_in  = ST_DONE;
            end
         endcase
      end
      out_byte_in = (action_in == ACT_APPEND) ? in_byte : 8'd0;
   end

endmodule

@@ hdl/header_address_extractor_core.sv @@
// Top level of the header address extractor: input stage, parser, result register.
// Depends on hae_pkg, hae_if (hae_req_if, hae_rsp_if) and hae_parser.
//
// Usage:
//   req_chan carries one header byte per beat plus new_header, which restarts
//   the parser (before-colon state) ahead of that byte. A 0 byte ends the text.
//   rsp_chan returns exactly one beat per request beat, in order: the action
//   code and, for an append, the byte to append (0 otherwise).
//   Path: a request beat is held in the input register, decoded by the parser and
//   captured in the output register (two register stages).
//   Throughput: one beat per cycle while rsp_chan.ready stays high; the parse
//   state register closes its loop through the combinational byte decode.
//   Stalls: when rsp_chan.ready is low the response holds; the input stage
//   keeps one more beat, after which req_chan.ready drops until space frees.
//   Reset: both stages empty, parser in before-colon state.
module header_address_extractor_core
   import hae_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hae_req_if.sink   req_chan,
   hae_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic       in_new_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   action_type out_action_ff;
   logic [7:0] out_byte_ff;

   logic       advance;
   action_type action_in;
   logic [7:0] out_byte_in;

   // input stage moves on when the result register is empty or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) in_valid_ff <= req_chan.valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_new_ff  <= req_chan.new_header;
         in_byte_ff <= req_chan.in_byte;
      end
      if (advance) begin
         out_action_ff <= action_in;
         out_byte_ff   <= out_byte_in;
      end
   end

   hae_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .new_header  (in_new_ff),
      .in_byte     (in_byte_ff),
      .action_in   (action_in),
      .out_byte_in (out_byte_in)
   );

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.action   = out_action_ff;
   assign rsp_chan.out_byte = out_byte_ff;

endmodule

@@ verif/header_address_extractor_core_tb.sv @@
// Self-checking testbench for header_address_extractor_core: drives header bytes over the
// request channel and checks every response beat against an in-bench parser model.
// Depends on hae_pkg, hae_if (hae_req_if, hae_rsp_if) and the core RTL.
module header_address_extractor_core_tb;
   import hae_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEM_TOTAL = 1575;
   localparam int unsigned HOLD_AT    = 500;
   localparam int unsigned HOLD_LEN   = 400;
   localparam string       ADDR_CHARS = "abcdefghijklmnopqrstuvwxyzABCXYZ0123456789@.-_+=:";

   typedef struct {
      logic        new_header;
      logic [7:0]  in_byte;
      int unsigned gap;
   } header_byte_type;

   typedef struct {
      action_type  action;
      logic [7:0]  out_byte;
   } action_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hae_req_if req_chan ();
   hae_rsp_if rsp_chan ();

   header_address_extractor_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   header_byte_type header_bytes_q[$];
   action_beat_type pending_actions_q[$];
   parse_state_type line_state;
   int unsigned     bytes_sent;
   int unsigned     actions_seen;
   int unsigned     fail_count;
   int unsigned     send_mode;
   int unsigned     rcv_mode;
   int unsigned     send_wait;
   int unsigned     rcv_wait;
   int unsigned     hold_left;

   // Parser model: one action per byte, state carried in line_state.
   function automatic action_beat_type extract_step(input logic nh, input logic [7:0] c);
      action_beat_type r;
      parse_state_type s;
      r.action   = ACT_NONE;
      r.out_byte = 8'h00;
      if (nh)
         line_state = ST_PRE;
      s = line_state;
      if (c == CH_NUL) begin
         r.action = ACT_END;
         s = ST_DONE;
      end else begin
         case (s)
            ST_PRE: begin
               if (c == CH_LF) begin
                  r.action = ACT_END;
                  s = ST_DONE;
               end else if (c == CH_COLON) begin
                  r.action = ACT_DISCARD;
                  s = ST_ADDR;
               end
            end
            ST_ADDR: begin
               if (c == CH_LF) begin
                  r.action = ACT_DONE;
                  s = ST_DONE;
               end else if (c == CH_COMMA) begin
                  r.action = ACT_DONE;
               end else if (c == CH_DQUOTE) begin
                  r.action = ACT_APPEND;
                  s = ST_QUOTE;
               end else if (c == CH_LPAREN) begin
                  s = ST_CMT;
               end else if (c == CH_LANGLE) begin
                  r.action = ACT_DISCARD;
                  s = ST_ANGLE;
               end else if (!(c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR})) begin
                  r.action = ACT_APPEND;
               end
            end
            ST_QUOTE: begin
               if (c == CH_LF) begin
                  r.action = ACT_BAD;
                  s = ST_DONE;
               end else begin
                  r.action = ACT_APPEND;
                  if (c == CH_DQUOTE)
                     s = ST_ADDR;
               end
            end
            ST_CMT: begin
               if (c == CH_LF) begin
                  r.action = ACT_BAD;
                  s = ST_DONE;
               end else if (c == CH_RPAREN) begin
                  s = ST_ADDR;
               end
            end
            ST_ANGLE: begin
               if (c == CH_RANGLE) begin
                  r.action = ACT_DONE;
                  s = ST_ADDR;
               end else if (c == CH_LANGLE) begin
                  r.action = ACT_DISCARD;
               end else begin
                  r.action = ACT_APPEND;
                  if (c == CH_DQUOTE)
                     s = ST_AQUOTE;
               end
            end
            ST_AQUOTE: begin
               if (c == CH_LF) begin
                  r.action = ACT_BAD;
                  s = ST_DONE;
               end else begin
                  r.action = ACT_APPEND;
                  if (c == CH_DQUOTE)
                     s = ST_ANGLE;
               end
            end
            default: begin
               r.action = ACT_END;
               s = ST_DONE;
            end
         endcase
      end
      line_state = s;
      if (r.action == ACT_APPEND)
         r.out_byte = c;
      return r;
   endfunction

   // mode 0: back to back, 1: uniform gaps, 2: mostly none with rare long gaps
   function automatic int unsigned draw_wait(input int unsigned mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, 13);
         default: return ($urandom_range(0, 7) == 0) ? 13 : 0;
      endcase
   endfunction

   function automatic logic [7:0] any_byte_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (c == a || c == b || c == CH_LF)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic add_byte(input logic nh, input logic [7:0] b);
      header_byte_type hb;
      if (header_bytes_q.size() % 60 == 0)
         send_mode = $urandom_range(0, 2);
      hb.new_header = nh;
      hb.in_byte    = b;
      hb.gap        = draw_wait(send_mode);
      header_bytes_q.push_back(hb);
   endtask

   task automatic add_word(input int unsigned n);
      repeat (n)
         add_byte(1'b0, ADDR_CHARS[$urandom_range(0, ADDR_CHARS.len() - 1)]);
   endtask

   task automatic add_blanks();
      logic [7:0] blanks[5];
      blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
      repeat ($urandom_range(0, 2))
         add_byte(1'b0, blanks[$urandom_range(0, 4)]);
   endtask

   // A well-formed header line with random content, sometimes broken at the end.
   task automatic add_header();
      int unsigned n_addr;
      add_byte(1'b1, "X");
      add_word($urandom_range(0, 5));
      add_byte(1'b0, CH_COLON);
      n_addr = $urandom_range(1, 4);
      for (int i = 0; i < n_addr; i++) begin
         add_blanks();
         case ($urandom_range(0, 3))
            0: begin
               add_word($urandom_range(1, 8));
               if ($urandom_range(0, 1)) begin
                  add_byte(1'b0, "@");
                  add_word($urandom_range(1, 6));
               end
            end
            1: begin
               add_byte(1'b0, CH_DQUOTE);
               repeat ($urandom_range(0, 5))
                  add_byte(1'b0, any_byte_except(CH_DQUOTE, CH_DQUOTE));
               add_byte(1'b0, CH_DQUOTE);
               add_word($urandom_range(0, 4));
            end
            2: begin
               add_word($urandom_range(0, 4));
               add_byte(1'b0, CH_LPAREN);
               repeat ($urandom_range(0, 5))
                  add_byte(1'b0, any_byte_except(CH_RPAREN, CH_RPAREN));
               add_byte(1'b0, CH_RPAREN);
               add_word($urandom_range(0, 4));
            end
            default: begin
               add_word($urandom_range(0, 4));
               add_blanks();
               add_byte(1'b0, CH_LANGLE);
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 5) == 0) begin
                     add_byte(1'b0, CH_DQUOTE);
                     repeat ($urandom_range(0, 3))
                        add_byte(1'b0, any_byte_except(CH_DQUOTE, CH_DQUOTE));
                     add_byte(1'b0, CH_DQUOTE);
                  end else begin
                     add_byte(1'b0, any_byte_except(CH_RANGLE, CH_DQUOTE));
                  end
               end
               add_byte(1'b0, CH_RANGLE);
            end
         endcase
         add_blanks();
         if (i + 1 < n_addr)
            add_byte(1'b0, CH_COMMA);
      end
      case ($urandom_range(0, 9))
         7: add_byte(1'b0, CH_NUL);
         8: begin
            add_byte(1'b0, CH_DQUOTE);
            add_word($urandom_range(0, 3));
            add_byte(1'b0, CH_LF);
         end
         9: begin
            add_byte(1'b0, CH_LPAREN);
            add_word($urandom_range(0, 3));
            add_byte(1'b0, CH_LF);
         end
         default: add_byte(1'b0, CH_LF);
      endcase
      // trailing bytes after the line has ended
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2))
            add_byte(1'b0, 8'($urandom_range(0, 255)));
   endtask

   // Driver: one beat offered at a time, held until accepted.
   always @(posedge clock) begin
      header_byte_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pending_actions_q.push_back(extract_step(req_chan.new_header, req_chan.in_byte));
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_chan.valid <= 1'b0;
            end else if (header_bytes_q.size() != 0) begin
               nxt = header_bytes_q.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.new_header <= nxt.new_header;
               req_chan.in_byte    <= nxt.in_byte;
               if (header_bytes_q.size() != 0)
                  send_wait = header_bytes_q[0].gap;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response beat, paces ready, and holds off once for a long stretch.
   always @(posedge clock) begin
      logic            rdy;
      action_beat_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rcv_wait  = 0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_actions_q.size() == 0) begin
               $error("unexpected response beat: action=%0d out_byte=%02h",
                      rsp_chan.action, rsp_chan.out_byte);
               fail_count++;
            end else begin
               want = pending_actions_q.pop_front();
               if (rsp_chan.action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, rsp_chan.action);
                  fail_count++;
               end
               if (rsp_chan.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_chan.out_byte);
                  fail_count++;
               end
            end
            actions_seen++;
            if (actions_seen % 80 == 0)
               rcv_mode = $urandom_range(0, 2);
            if (actions_seen == HOLD_AT)
               hold_left = HOLD_LEN;
            rcv_wait = draw_wait(rcv_mode);
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (rcv_wait > 0) begin
            rcv_wait--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_chan.ready <= rdy;
      end
   end

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.new_header = 1'b0;
      req_chan.in_byte    = 8'h00;
      rsp_chan.ready      = 1'b0;
      line_state   = ST_PRE;
      bytes_sent   = 0;
      actions_seen = 0;
      fail_count   = 0;
      send_mode    = 0;
      rcv_mode     = 0;

      // newline before the colon, then a byte in the done state
      add_byte(1'b1, CH_LF);
      add_byte(1'b0, "z");
      // plain address, CR ignored, comma, quote left open at newline
      add_byte(1'b1, CH_COLON);
      add_byte(1'b0, "a");
      add_byte(1'b0, CH_CR);
      add_byte(1'b0, CH_COMMA);
      add_byte(1'b0, CH_DQUOTE);
      add_byte(1'b0, CH_LF);
      // comment closed, then a comment left open at newline
      add_byte(1'b1, CH_COLON);
      add_byte(1'b0, CH_LPAREN);
      add_byte(1'b0, CH_RPAREN);
      add_byte(1'b0, CH_LPAREN);
      add_byte(1'b0, CH_LF);
      // angle address: second '<' discards, newline appended, open quote at newline
      add_byte(1'b1, CH_COLON);
      add_byte(1'b0, CH_LANGLE);
      add_byte(1'b0, CH_LANGLE);
      add_byte(1'b0, CH_LF);
      add_byte(1'b0, CH_DQUOTE);
      add_byte(1'b0, CH_LF);
      // top byte value, '>' completes, newline ends the address list
      add_byte(1'b1, CH_COLON);
      add_byte(1'b0, CH_LANGLE);
      add_byte(1'b0, 8'hFF);
      add_byte(1'b0, CH_RANGLE);
      add_byte(1'b0, CH_LF);
      // end of text right at a new header
      add_byte(1'b1, CH_NUL);

      while (header_bytes_q.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 9) < 8) begin
            add_header();
         end else begin
            repeat ($urandom_range(1, 12))
               add_byte(($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (header_bytes_q.size() != 0 || bytes_sent == 0 || req_chan.valid ||
             pending_actions_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/hae_pkg.sv
hdl/hae_if.sv
hdl/hae_parser.sv
hdl/header_address_extractor_core.sv
verif/header_address_extractor_core_tb.sv
